### hdl/fspm_pkg.sv
// Shared types and constants for the frame slice ESC PWM mapper.
package fspm_pkg;

  // Input item kinds; the fourth code is ignored
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_SYNC = 2'd1,
    OP_TICK = 2'd2
  } opcode_t;

  // Register word indexes on the APB port
  typedef enum logic [1:0] {
    REG_BOARD_SLOT = 2'd0,
    REG_TIMEOUT    = 2'd1,
    REG_LED_DIV    = 2'd2
  } reg_index_t;

  // Result sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } emit_state_t;

  // Per-cycle control broadcast to every slot cell
  typedef struct packed {
    logic wr_en;
    logic shift;
  } cell_ctl_t;

  // Register resets
  localparam logic [2:0]  BOARD_SLOT_RST = 3'd0;
  localparam logic [23:0] TIMEOUT_RST    = 24'd200000;
  localparam logic [7:0]  LED_DIV_RST    = 8'd20;

  // Pulse mapping, all in microseconds
  localparam logic [10:0] PULSE_ZERO = 11'd1000;
  localparam logic [10:0] PULSE_BASE = 11'd1200;
  localparam logic [10:0] PULSE_MIN  = 11'd1000;
  localparam logic [10:0] PULSE_MAX  = 11'd2000;
  localparam logic [9:0]  PULSE_SPAN = 10'd800;

  // floor(x/255) = ((x+1) * 65793) >> 24 for x below 2^24
  localparam logic [16:0] RECIP_255   = 17'd65793;
  localparam int          RECIP_SHIFT = 24;

  // level = (pulse * 75) >> 5, i.e. pulse * 2.34375
  localparam logic [6:0] LEVEL_MUL   = 7'd75;
  localparam int         LEVEL_SHIFT = 5;

  localparam logic [24:0] TICK_MAX = 25'h1FFFFFF;

endpackage

### hdl/fspm_cell.sv
// One motor slot: holds a stored frame byte and passes it along the ring.
module fspm_cell #(
  parameter int IDX = 0,
  parameter int MW  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  fspm_pkg::cell_ctl_t ctl,
  input  logic [MW-1:0]     wr_sel,
  input  logic [7:0]        wr_data,
  input  logic [7:0]        shift_in,
  output logic [7:0]        value
);
  import fspm_pkg::*;

  logic [7:0] slot_byte;

  // Byte capture when addressed, rotation during result runs
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_byte <= 8'd0;
    end else if (ctl.wr_en && (wr_sel == MW'(IDX))) begin
      slot_byte <= wr_data;
    end else if (ctl.shift) begin
      slot_byte <= shift_in;
    end
  end

  assign value = slot_byte;

endmodule

### hdl/fspm_level.sv
// Three-stage pipeline mapping a stored byte to a PWM compare level.
module fspm_level (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        lvl_valid,
  output logic [12:0] lvl
);
  import fspm_pkg::*;

  logic        v1, v2, v3;
  logic        zero1;
  logic [17:0] scaled1;
  logic [10:0] pulse2;
  logic [12:0] level3;

  logic [34:0] recip_prod;
  logic [9:0]  quot;
  logic [10:0] pulse_raw;
  logic [10:0] pulse_clamp;
  logic [17:0] level_prod;

  // Stage 1: v*800 + 1, ready for the reciprocal multiply
  always_ff @(posedge clk) begin
    scaled1 <= 18'(in_byte) * 18'(PULSE_SPAN) + 18'd1;
    zero1   <= (in_byte == 8'd0);
  end

  // Stage 2: divide by 255, offset and clamp
  always_comb begin
    recip_prod = 35'(scaled1) * 35'(RECIP_255);
    quot       = recip_prod[RECIP_SHIFT +: 10];
    pulse_raw  = zero1 ? PULSE_ZERO : PULSE_BASE + 11'(quot);
    if (pulse_raw < PULSE_MIN) begin
      pulse_clamp = PULSE_MIN;
    end else if (pulse_raw > PULSE_MAX) begin
      pulse_clamp = PULSE_MAX;
    end else begin
      pulse_clamp = pulse_raw;
    end
  end

  always_ff @(posedge clk) begin
    pulse2 <= pulse_clamp;
  end

  // Stage 3: fixed-point scale to the compare level
  assign level_prod = 18'(pulse2) * 18'(LEVEL_MUL);

  always_ff @(posedge clk) begin
    level3 <= level_prod[LEVEL_SHIFT +: 13];
  end

  // Valid travels alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign lvl_valid = v3;
  assign lvl       = level3;

endmodule

### hdl/frame_slice_esc_pwm_mapper_core.sv
// Top level: frame slice ESC PWM mapper with APB registers and result sequencer.
//
// Frame bytes and microsecond ticks are taken one per cycle. A sync, or a
// tick that crosses the timeout, starts a run of MOTORS_PER_BOARD results;
// no input is taken until the last result of the run has been transferred.
// Each result is made in turn: the head slot is issued into the three-stage
// level pipeline, its level is loaded into the output register, and it is
// held there through any output stall. The motor slots form a ring of cells
// that rotates one place per transferred result and is back in order when
// the run ends. The led_on output is the current LED state, already updated
// by the sync that started the run.
module frame_slice_esc_pwm_mapper_core #(
  parameter int MOTORS_PER_BOARD = 8,
  parameter int FRAME_LENGTH     = 64
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  frame_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  motor_number,
  output logic [12:0] pwm_level,
  output logic        last_motor,
  output logic        led_on
);
  import fspm_pkg::*;

  localparam int MW = (MOTORS_PER_BOARD > 1) ? $clog2(MOTORS_PER_BOARD) : 1;
  localparam int PW = $clog2(FRAME_LENGTH + 1);
  localparam int CW = ((PW > 3 + MW) ? PW : 3 + MW) + 1;

  // Configuration registers
  logic [2:0]  board_slot;
  logic [23:0] timeout_ticks;
  logic [7:0]  led_sync_divide;

  // Block state
  logic [PW-1:0] frame_position;
  logic [24:0]   ticks_since_sync;
  logic          timed_out;
  logic [7:0]    sync_count;
  logic          led_state;

  // Sequencer
  emit_state_t   state, state_next;
  logic [MW-1:0] mot;
  logic          zero_run;
  logic [2:0]    motor_q;
  logic [12:0]   level_q;
  logic          last_q;

  logic          in_xfer, out_xfer, cfg_wr;
  logic          is_byte, is_sync, is_tick;
  logic          trip;
  logic          start_run;
  logic          pipe_issue, load_out, run_last;
  logic [24:0]   tick_inc;
  logic [7:0]    sync_inc;
  logic [CW-1:0] pos_w, win_start;
  logic          in_win;
  logic [MW-1:0] wr_sel;
  cell_ctl_t     cell_ctl;
  logic [7:0]    slot_val [MOTORS_PER_BOARD];
  logic          lvl_valid;
  logic [12:0]   lvl;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_slot      <= BOARD_SLOT_RST;
      timeout_ticks   <= TIMEOUT_RST;
      led_sync_divide <= LED_DIV_RST;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[3:2]))
        REG_BOARD_SLOT: board_slot      <= pwdata[2:0];
        REG_TIMEOUT:    timeout_ticks   <= pwdata[23:0];
        REG_LED_DIV:    led_sync_divide <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_BOARD_SLOT: prdata = {29'd0, board_slot};
      REG_TIMEOUT:    prdata = {8'd0, timeout_ticks};
      REG_LED_DIV:    prdata = {24'd0, led_sync_divide};
      default:        prdata = 32'd0;
    endcase
  end

  // Input decode
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign is_byte  = in_xfer && (opcode_t'(opcode) == OP_BYTE);
  assign is_sync  = in_xfer && (opcode_t'(opcode) == OP_SYNC);
  assign is_tick  = in_xfer && (opcode_t'(opcode) == OP_TICK);

  // Window check for the byte position
  assign pos_w     = CW'(frame_position);
  assign win_start = CW'(board_slot) * CW'(MOTORS_PER_BOARD);
  assign in_win    = (pos_w >= win_start) &&
                     (pos_w < win_start + CW'(MOTORS_PER_BOARD));
  assign wr_sel    = MW'(pos_w - win_start);

  // Frame position, saturating at the frame length
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
    end else if (is_sync) begin
      frame_position <= '0;
    end else if (is_byte && (frame_position < PW'(FRAME_LENGTH))) begin
      frame_position <= frame_position + PW'(1);
    end
  end

  // Watchdog
  assign tick_inc = (ticks_since_sync == TICK_MAX) ? ticks_since_sync
                                                   : ticks_since_sync + 25'd1;
  assign trip     = is_tick && !timed_out && (tick_inc > {1'b0, timeout_ticks});

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_sync <= '0;
      timed_out        <= 1'b0;
    end else if (is_sync) begin
      ticks_since_sync <= '0;
      timed_out        <= 1'b0;
    end else if (is_tick) begin
      ticks_since_sync <= tick_inc;
      if (trip) begin
        timed_out <= 1'b1;
      end
    end
  end

  // LED divider
  assign sync_inc = sync_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_count <= '0;
      led_state  <= 1'b1;
    end else if (is_sync) begin
      if (sync_inc >= led_sync_divide) begin
        sync_count <= '0;
        led_state  <= !led_state;
      end else begin
        sync_count <= sync_inc;
      end
    end
  end

  // Ring of motor slot cells; cell 0 is the head
  assign cell_ctl.wr_en = is_byte && in_win;
  assign cell_ctl.shift = out_xfer;

  for (genvar k = 0; k < MOTORS_PER_BOARD; k++) begin : g_cell
    localparam int NXT = (k == MOTORS_PER_BOARD - 1) ? 0 : k + 1;
    fspm_cell #(
      .IDX (k),
      .MW  (MW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .wr_sel   (wr_sel),
      .wr_data  (frame_byte),
      .shift_in (slot_val[NXT]),
      .value    (slot_val[k])
    );
  end

  // Level mapping pipeline fed from the head cell
  fspm_level u_level (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pipe_issue),
    .in_byte   (slot_val[0]),
    .lvl_valid (lvl_valid),
    .lvl       (lvl)
  );

  // Result sequencer
  assign start_run = is_sync || trip;
  assign out_valid = (state == ST_OUT);
  assign out_xfer  = out_valid && out_ready;
  assign run_last  = (mot == MW'(MOTORS_PER_BOARD - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pipe_issue = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start_run) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        pipe_issue = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (lvl_valid) begin
          load_out   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = run_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Motor counter and run kind
  always_ff @(posedge clk) begin
    if (rst) begin
      mot      <= '0;
      zero_run <= 1'b0;
    end else if (start_run) begin
      mot      <= '0;
      zero_run <= trip;
    end else if (out_xfer && !run_last) begin
      mot <= mot + MW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      motor_q <= 3'(mot);
      level_q <= zero_run ? 13'd0 : lvl;
      last_q  <= run_last;
    end
  end

  assign motor_number = motor_q;
  assign pwm_level    = level_q;
  assign last_motor   = last_q;
  assign led_on       = led_state;

  // Checks
  a_no_input_during_run: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  a_sync_starts_run: assert property (@(posedge clk) disable iff (rst)
    is_sync |=> (state == ST_ISSUE))
    else $error("sync did not start a result run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_motor) |=> in_ready)
    else $error("run did not end after the last motor");

  a_zero_run_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_run) |-> (pwm_level == 13'd0))
    else $error("nonzero level in a timeout run");

endmodule
